// File: rtl/core/flm_pkg.sv
// ============================================================================
// Frame load monitor package
// Constants, register map and action codes shared by the frame load monitor.
// ============================================================================
`default_nettype none

package flm_pkg;

   // Register map (byte address = 4 * index)
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0] REG_BUDGET    = 2'd0;
   localparam logic [1:0] REG_SMOOTHING = 2'd1;
   localparam logic [1:0] REG_PEAK_HOLD = 2'd2;

   // Action codes carried in the request's tuser
   localparam logic [1:0] ACT_FRAME   = 2'd0;
   localparam logic [1:0] ACT_OVERRUN = 2'd1;
   localparam logic [1:0] ACT_CLEAR   = 2'd2;

   // Arithmetic constants
   localparam logic [6:0]  PERCENT     = 7'd100;
   localparam logic [14:0] FULL_LOAD   = 15'd25600;
   localparam logic [16:0] DECAY_KEEP  = 17'd64880;
   localparam logic [16:0] DECAY_NEW   = 17'd655;
   localparam logic [16:0] SMOOTH_MIN  = 17'd66;
   localparam logic [16:0] SMOOTH_MAX  = 17'd65536;
   localparam logic [16:0] SMOOTH_RST  = 17'd6554;
   localparam logic [48:0] ROUND_HALF  = 49'd32768;

   // Serial unit step counts
   localparam int unsigned DIV_STEPS = 48;
   localparam int unsigned MAC_STEPS = 17;

   // Payload widths
   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 144;

endpackage : flm_pkg

`default_nettype wire

// File: rtl/core/frame_load_monitor_top.sv
// ============================================================================
// Frame load monitor
// Per-frame load, moving average, held/decaying peak and long-term average.
// ============================================================================
// Processing: one request at a time; a frame runs the 48-step serial divider
//    for the load (not with a zero budget) and for the long-term average, and
//    the 17-step serial MAC for the moving average and, when the peak decays,
//    for the decay. Other actions go straight to the result.
// Reset: synchronous, active high; restores statistics, peak stamp and the
//    registers to their reset values. No clearing pass is needed.
`default_nettype none

module frame_load_monitor_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Request channel
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // [31:0] elapsed_ticks, [63:32] now_time
   input  wire logic [flm_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] action
   input  wire logic [1:0]                     req_tuser,
   // Result channel
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [15:0] current_load, [31:16] smoothed_load, [47:32] peak_load,
   // [63:48] average_load, [78:64] headroom, [110:79] overrun_count,
   // [142:111] frame_count, [143] zero
   output logic [flm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Configuration port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [flm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   import flm_pkg::*;

   // The sequencer walks through: load multiply, load division, moving
   // average, optional peak decay, and the long-term average division.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_LOAD_FIN,
      ST_MAC,
      ST_EMA_FIN,
      ST_PEAK_FIN,
      ST_AVG_SETUP,
      ST_AVG_FIN,
      ST_RESULT
   } state_type;

   state_type state_ff;

   // Configuration registers
   logic [31:0] budget_ff;
   logic [16:0] smoothing_ff;
   logic [31:0] hold_ff;

   // Statistics state
   logic [15:0] last_load_ff;
   logic [31:0] avg_state_ff;
   logic [31:0] peak_ff;
   logic [31:0] stamp_ff;
   logic [47:0] load_sum_ff;
   logic [31:0] frames_ff;
   logic [31:0] overruns_ff;
   logic [15:0] avg_load_ff;

   // Captured request
   logic [31:0] elapsed_ff;
   logic [31:0] now_ff;

   // Bit-serial divider
   logic [47:0] dvd_ff;
   logic [31:0] div_ff;
   logic [31:0] rem_ff;
   logic [15:0] quot_ff;
   logic        sat_ff;
   logic        avg_pass_ff;

   // Bit-serial multiply-accumulate: acc = x * mb + y * ma
   logic [48:0] acc_ff;
   logic [31:0] mac_x_ff;
   logic [31:0] mac_y_ff;
   logic [32:0] mac_xy_ff;
   logic [16:0] mb_ff;
   logic [16:0] ma_ff;
   logic        mac_peak_ff;

   logic [5:0]  cnt_ff;

   // Result register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // Combinational helpers
   logic        req_fire;
   logic        cfg_write;
   logic [32:0] div_trial;
   logic        div_ge;
   logic [32:0] div_diff;
   logic [31:0] rem_in;
   logic [15:0] quot_sat;
   logic [32:0] mac_addend;
   logic [48:0] acc_in;
   logic [48:0] mac_round;
   logic [31:0] mac_result;
   logic [16:0] smooth_a;
   logic [16:0] smooth_b;
   logic [38:0] load_prod;
   logic [31:0] scaled;
   logic [31:0] since;
   logic [48:0] sum_add;
   logic [15:0] smooth_val;
   logic [14:0] head_val;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // One restoring division step: bring in the next dividend bit, subtract
   // the divisor when it fits. Quotient bits beyond the sixteenth only mark
   // saturation.
   assign div_trial = {rem_ff, dvd_ff[47]};
   assign div_ge    = (div_trial >= {1'b0, div_ff});
   assign div_diff  = div_trial - {1'b0, div_ff};
   assign rem_in    = div_ge ? div_diff[31:0] : div_trial[31:0];
   assign quot_sat  = sat_ff ? 16'hFFFF : quot_ff;

   // One multiply-accumulate step, multiplier bits taken MSB first. The sum
   // x + y is precomputed so a step holds a single wide add.
   always_comb begin
      unique case ({mb_ff[16], ma_ff[16]})
         2'b10:   mac_addend = {1'b0, mac_x_ff};
         2'b01:   mac_addend = {1'b0, mac_y_ff};
         2'b11:   mac_addend = mac_xy_ff;
         default: mac_addend = 33'd0;
      endcase
   end

   assign acc_in     = {acc_ff[47:0], 1'b0} + {16'd0, mac_addend};
   assign mac_round  = acc_ff + ROUND_HALF;
   assign mac_result = mac_round[47:16];

   // Smoothing factor is clamped when used; the register keeps its bits.
   always_comb begin
      priority if (smoothing_ff < SMOOTH_MIN) begin
         smooth_a = SMOOTH_MIN;
      end else if (smoothing_ff > SMOOTH_MAX) begin
         smooth_a = SMOOTH_MAX;
      end else begin
         smooth_a = smoothing_ff;
      end
   end

   assign smooth_b   = SMOOTH_MAX - smooth_a;
   assign load_prod  = 39'(elapsed_ff) * 39'(PERCENT);
   assign scaled     = {last_load_ff, 16'd0};
   assign since      = now_ff - stamp_ff;
   assign sum_add    = {1'b0, load_sum_ff} + {33'd0, quot_sat};
   assign smooth_val = avg_state_ff[31:16];
   assign head_val   = (smooth_val >= {1'b0, FULL_LOAD}) ? 15'd0
                       : 15'({1'b0, FULL_LOAD} - smooth_val);

   // Register read-back
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_BUDGET:    csr_prdata = budget_ff;
         REG_SMOOTHING: csr_prdata = {15'd0, smoothing_ff};
         REG_PEAK_HOLD: csr_prdata = hold_ff;
         default:       csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         budget_ff    <= 32'd0;
         smoothing_ff <= SMOOTH_RST;
         hold_ff      <= 32'd0;
         last_load_ff <= 16'd0;
         avg_state_ff <= 32'd0;
         peak_ff      <= 32'd0;
         stamp_ff     <= 32'd0;
         load_sum_ff  <= 48'd0;
         frames_ff    <= 32'd0;
         overruns_ff  <= 32'd0;
         avg_load_ff  <= 16'd0;
         avg_pass_ff  <= 1'b0;
         mac_peak_ff  <= 1'b0;
         cnt_ff       <= 6'd0;
      end else begin
         if (cfg_write) begin
            unique case (csr_paddr[3:2])
               REG_BUDGET:    budget_ff    <= csr_pwdata;
               REG_SMOOTHING: smoothing_ff <= csr_pwdata[16:0];
               REG_PEAK_HOLD: hold_ff      <= csr_pwdata;
               default:       ;
            endcase
         end

         // In the result state the valid flag is owned by that state's arm.
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_RESULT)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  elapsed_ff <= req_tdata[31:0];
                  now_ff     <= req_tdata[63:32];
                  unique case (req_tuser)
                     ACT_FRAME: begin
                        state_ff <= ST_MUL;
                     end
                     ACT_OVERRUN: begin
                        if (overruns_ff != 32'hFFFF_FFFF) begin
                           overruns_ff <= overruns_ff + 32'd1;
                        end
                        state_ff <= ST_RESULT;
                     end
                     ACT_CLEAR: begin
                        last_load_ff <= 16'd0;
                        avg_state_ff <= 32'd0;
                        peak_ff      <= 32'd0;
                        load_sum_ff  <= 48'd0;
                        frames_ff    <= 32'd0;
                        overruns_ff  <= 32'd0;
                        avg_load_ff  <= 16'd0;
                        state_ff     <= ST_RESULT;
                     end
                     default: begin
                        state_ff <= ST_RESULT;
                     end
                  endcase
               end
            end

            ST_MUL: begin
               // Dividend is elapsed * 25600, i.e. elapsed * 100 shifted by 8.
               quot_ff <= 16'd0;
               sat_ff  <= 1'b0;
               if (budget_ff == 32'd0) begin
                  state_ff <= ST_LOAD_FIN;
               end else begin
                  dvd_ff      <= {1'b0, load_prod, 8'd0};
                  div_ff      <= budget_ff;
                  rem_ff      <= 32'd0;
                  cnt_ff      <= 6'd0;
                  avg_pass_ff <= 1'b0;
                  state_ff    <= ST_DIV;
               end
            end

            ST_DIV: begin
               dvd_ff  <= {dvd_ff[46:0], 1'b0};
               rem_ff  <= rem_in;
               quot_ff <= {quot_ff[14:0], div_ge};
               sat_ff  <= sat_ff | quot_ff[15];
               cnt_ff  <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(DIV_STEPS - 1)) begin
                  state_ff <= avg_pass_ff ? ST_AVG_FIN : ST_LOAD_FIN;
               end
            end

            ST_LOAD_FIN: begin
               last_load_ff <= quot_sat;
               if (frames_ff != 32'hFFFF_FFFF) begin
                  frames_ff   <= frames_ff + 32'd1;
                  load_sum_ff <= sum_add[48] ? 48'hFFFF_FFFF_FFFF : sum_add[47:0];
               end
               // Moving average: s * (1 - a) + L * a, both in Q16.16.
               mac_x_ff    <= avg_state_ff;
               mac_y_ff    <= {quot_sat, 16'd0};
               mac_xy_ff   <= {1'b0, avg_state_ff} + {1'b0, quot_sat, 16'd0};
               mb_ff       <= smooth_b;
               ma_ff       <= smooth_a;
               acc_ff      <= 49'd0;
               cnt_ff      <= 6'd0;
               mac_peak_ff <= 1'b0;
               state_ff    <= ST_MAC;
            end

            ST_MAC: begin
               acc_ff <= acc_in;
               mb_ff  <= {mb_ff[15:0], 1'b0};
               ma_ff  <= {ma_ff[15:0], 1'b0};
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(MAC_STEPS - 1)) begin
                  state_ff <= mac_peak_ff ? ST_PEAK_FIN : ST_EMA_FIN;
               end
            end

            ST_EMA_FIN: begin
               avg_state_ff <= mac_result;
               priority if (scaled > peak_ff) begin
                  // New peak: take it and restart the hold time.
                  peak_ff  <= scaled;
                  stamp_ff <= now_ff;
                  state_ff <= ST_AVG_SETUP;
               end else if (since > hold_ff) begin
                  // Hold expired: decay toward the current load.
                  mac_x_ff    <= peak_ff;
                  mac_y_ff    <= scaled;
                  mac_xy_ff   <= {1'b0, peak_ff} + {1'b0, scaled};
                  mb_ff       <= DECAY_KEEP;
                  ma_ff       <= DECAY_NEW;
                  acc_ff      <= 49'd0;
                  cnt_ff      <= 6'd0;
                  mac_peak_ff <= 1'b1;
                  state_ff    <= ST_MAC;
               end else begin
                  state_ff <= ST_AVG_SETUP;
               end
            end

            ST_PEAK_FIN: begin
               peak_ff  <= (mac_result < scaled) ? scaled : mac_result;
               state_ff <= ST_AVG_SETUP;
            end

            ST_AVG_SETUP: begin
               if (frames_ff == 32'd0) begin
                  avg_load_ff <= 16'd0;
                  state_ff    <= ST_RESULT;
               end else begin
                  dvd_ff      <= load_sum_ff;
                  div_ff      <= frames_ff;
                  rem_ff      <= 32'd0;
                  quot_ff     <= 16'd0;
                  sat_ff      <= 1'b0;
                  cnt_ff      <= 6'd0;
                  avg_pass_ff <= 1'b1;
                  state_ff    <= ST_DIV;
               end
            end

            ST_AVG_FIN: begin
               avg_load_ff <= quot_sat;
               state_ff    <= ST_RESULT;
            end

            ST_RESULT: begin
               // Hold here until the result register is free.
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {1'b0, frames_ff, overruns_ff, head_val,
                                   avg_load_ff, peak_ff[31:16], smooth_val,
                                   last_load_ff};
                  state_ff     <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   // The partial remainder always stays below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

   // The frame counter only moves backward on a clear request.
   assert property (@(posedge clock) disable iff (reset)
      !(req_fire && (req_tuser == ACT_CLEAR)) |=> (frames_ff >= $past(frames_ff)))
      else $error("frame count decreased without clear");

   // Headroom and smoothed load add up to full load unless headroom is floored.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff[31:16] >= {1'b0, FULL_LOAD}) ?
                        (rsp_data_ff[78:64] == 15'd0) :
                        ({1'b0, rsp_data_ff[78:64]} + rsp_data_ff[31:16]
                         == {1'b0, FULL_LOAD})))
      else $error("headroom inconsistent with smoothed load");

   // The peak never falls below the latest load.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[47:32] >= rsp_data_ff[15:0]))
      else $error("peak load below current load");
`endif

endmodule : frame_load_monitor_top

`default_nettype wire

// File: bench/tb_top.sv
// ============================================================================
// Frame load monitor testbench
// Sends frame, overrun, clear and unused requests to the frame load monitor
// and compares every result field with a cycle-free model of the statistics.
// Register settings are changed only while the block is idle. Both stream
// sides idle at random, and the result side holds off for long spells.
// ============================================================================
`timescale 1ns / 100ps

module tb_top;

   import flm_pkg::*;

   // Action code 3 has no meaning; the block reports its state unchanged.
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // Cycles without any handshake before the run is declared hung. The worst
   // honest gap is a long result hold-off plus a decaying frame's latency.
   localparam int unsigned STALL_LIMIT = 5000;
   // Longest latency in the block, padded, used as the settle time at the end.
   localparam int unsigned SETTLE_CYCLES = 150;
   localparam int unsigned ITEMS_PER_SETTING = 75;

   // One result, laid out exactly as rsp_tdata, most significant field first.
   typedef struct packed {
      logic        spare;
      logic [31:0] frames;
      logic [31:0] overruns;
      logic [14:0] headroom;
      logic [15:0] average;
      logic [15:0] peak;
      logic [15:0] smoothed;
      logic [15:0] current;
   } load_report_type;

   typedef enum logic {ROW_REQUEST, ROW_REGISTER} row_kind_type;

   // A directed step: either a request (code = action, arg_a = elapsed ticks,
   // arg_b = timestamp) or a register write (code = index, arg_a = value).
   typedef struct packed {
      row_kind_type    kind;
      logic [1:0]      code;
      logic [31:0]     arg_a;
      logic [31:0]     arg_b;
      logic            typed;
      load_report_type want;
   } plan_row_type;

   // Results that can be read straight off the behavior.
   localparam load_report_type NO_REPORT = '0;
   localparam load_report_type ZERO_BUDGET_FRAME = '{spare: 1'b0, frames: 32'd1,
      overruns: 32'd0, headroom: 15'd25600, average: 16'd0, peak: 16'd0,
      smoothed: 16'd0, current: 16'd0};
   localparam load_report_type ONE_OVERRUN = '{spare: 1'b0, frames: 32'd1,
      overruns: 32'd1, headroom: 15'd25600, average: 16'd0, peak: 16'd0,
      smoothed: 16'd0, current: 16'd0};
   localparam load_report_type CLEARED = '{spare: 1'b0, frames: 32'd0,
      overruns: 32'd0, headroom: 15'd25600, average: 16'd0, peak: 16'd0,
      smoothed: 16'd0, current: 16'd0};
   localparam load_report_type SATURATED = '{spare: 1'b0, frames: 32'd1,
      overruns: 32'd0, headroom: 15'd0, average: 16'hFFFF, peak: 16'hFFFF,
      smoothed: 16'hFFFF, current: 16'hFFFF};

   localparam int DIRECTED_ROWS = 25;
   localparam plan_row_type DIRECTED_PLAN [DIRECTED_ROWS] = '{
      // Reset values: zero budget, so any frame gives zero load.
      '{ROW_REQUEST,  ACT_FRAME,     32'hFFFF_FFFF, 32'd0,         1'b1, ZERO_BUDGET_FRAME},
      '{ROW_REQUEST,  ACT_OVERRUN,   32'd0,         32'd0,         1'b1, ONE_OVERRUN},
      '{ROW_REQUEST,  ACT_UNUSED,    32'h1234_5678, 32'h9ABC_DEF0, 1'b1, ONE_OVERRUN},
      '{ROW_REQUEST,  ACT_CLEAR,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, CLEARED},
      // One-tick budget saturates the load; full weight makes the average jump.
      '{ROW_REGISTER, REG_BUDGET,    32'd1,         32'd0,         1'b0, NO_REPORT},
      '{ROW_REGISTER, REG_SMOOTHING, 32'd65536,     32'd0,         1'b0, NO_REPORT},
      '{ROW_REQUEST,  ACT_FRAME,     32'hFFFF_FFFF, 32'd100,       1'b1, SATURATED},
      '{ROW_REQUEST,  ACT_FRAME,     32'd0,         32'd200,       1'b0, NO_REPORT},
      // Weight below the floor, endless hold, widest budget.
      '{ROW_REGISTER, REG_SMOOTHING, 32'd0,         32'd0,         1'b0, NO_REPORT},
      '{ROW_REGISTER, REG_PEAK_HOLD, 32'hFFFF_FFFF, 32'd0,         1'b0, NO_REPORT},
      '{ROW_REGISTER, REG_BUDGET,    32'hFFFF_FFFF, 32'd0,         1'b0, NO_REPORT},
      '{ROW_REQUEST,  ACT_FRAME,     32'hFFFF_FFFF, 32'd300,       1'b0, NO_REPORT},
      // Weight above full scale is clamped to one.
      '{ROW_REGISTER, REG_SMOOTHING, 32'h0001_FFFF, 32'd0,         1'b0, NO_REPORT},
      '{ROW_REQUEST,  ACT_FRAME,     32'h8000_0000, 32'd400,       1'b0, NO_REPORT},
      '{ROW_REQUEST,  ACT_OVERRUN,   32'hFFFF_FFFF, 32'd0,         1'b0, NO_REPORT},
      // Budget of 25600 makes the load equal to the elapsed ticks.
      '{ROW_REGISTER, REG_BUDGET,    32'd25600,     32'd0,         1'b0, NO_REPORT},
      '{ROW_REGISTER, REG_PEAK_HOLD, 32'd1000,      32'd0,         1'b0, NO_REPORT},
      '{ROW_REQUEST,  ACT_FRAME,     32'd30000,     32'd1000,      1'b0, NO_REPORT},
      '{ROW_REQUEST,  ACT_FRAME,     32'd100,       32'd1500,      1'b0, NO_REPORT},
      '{ROW_REQUEST,  ACT_FRAME,     32'd100,       32'd2501,      1'b0, NO_REPORT},
      '{ROW_REQUEST,  ACT_FRAME,     32'd200,       32'hFFFF_FF00, 1'b0, NO_REPORT},
      '{ROW_REQUEST,  ACT_FRAME,     32'd65535,     32'h0000_0010, 1'b0, NO_REPORT},
      '{ROW_REQUEST,  ACT_CLEAR,     32'd0,         32'd0,         1'b1, CLEARED},
      // One below the weight floor; the peak stamp survived the clear.
      '{ROW_REGISTER, REG_SMOOTHING, 32'd65,        32'd0,         1'b0, NO_REPORT},
      '{ROW_REQUEST,  ACT_FRAME,     32'd5,         32'd20,        1'b0, NO_REPORT}
   };

   // ---------------------------------------------------------------------------
   // Block ports. Every input holds a known value from time zero.
   // ---------------------------------------------------------------------------
   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [1:0]            req_tuser   = ACT_FRAME;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   frame_load_monitor_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ---------------------------------------------------------------------------
   // Shadow of the block: register copies and statistics, both at reset values.
   // ---------------------------------------------------------------------------
   logic [31:0] budget_cfg    = '0;
   logic [16:0] smoothing_cfg = SMOOTH_RST;
   logic [31:0] hold_cfg      = '0;

   logic [15:0] last_load     = '0;
   logic [31:0] ema_q16       = '0;
   logic [31:0] peak_q16      = '0;
   logic [31:0] peak_stamp    = '0;
   logic [47:0] load_total    = '0;
   logic [31:0] frame_tally   = '0;
   logic [31:0] overrun_tally = '0;

   load_report_type reports_due [$];
   int unsigned  error_count        = 0;
   int unsigned  sender_idle_pct    = 0;
   int unsigned  receiver_stall_pct = 0;
   logic [31:0]  now_cursor         = '0;

   // Applies one request to the shadow state and returns the result it gives.
   function automatic load_report_type advance_monitor(input logic [1:0] action,
                                                       input logic [31:0] elapsed,
                                                       input logic [31:0] now);
      logic [63:0]     load;
      logic [63:0]     scaled;
      logic [63:0]     weight;
      logic [63:0]     blend;
      logic [63:0]     total;
      logic [63:0]     mean;
      logic [31:0]     since;
      load_report_type rpt;

      case (action)
         ACT_FRAME: begin
            if (budget_cfg == 0) begin
               load = 0;
            end else begin
               load = (64'(elapsed) * 64'(FULL_LOAD)) / 64'(budget_cfg);
               if (load > 64'hFFFF) load = 64'hFFFF;
            end
            scaled = load << 16;

            weight = 64'(smoothing_cfg);
            if (weight < 64'(SMOOTH_MIN)) weight = 64'(SMOOTH_MIN);
            if (weight > 64'(SMOOTH_MAX)) weight = 64'(SMOOTH_MAX);

            last_load = load[15:0];
            blend = (64'(ema_q16) * (64'(SMOOTH_MAX) - weight) + scaled * weight
                     + 64'd32768) >> 16;
            ema_q16 = blend[31:0];

            // The peak rises at once; it decays only once the hold has run out,
            // measured on the wrapping timestamp, and never falls below the load.
            since = now - peak_stamp;
            if (scaled > 64'(peak_q16)) begin
               peak_q16   = scaled[31:0];
               peak_stamp = now;
            end else if (since > hold_cfg) begin
               blend = (64'(peak_q16) * 64'(DECAY_KEEP) + scaled * 64'(DECAY_NEW)
                        + 64'd32768) >> 16;
               if (blend < scaled) blend = scaled;
               peak_q16 = blend[31:0];
            end

            // Once the frame tally is full the sum freezes with it.
            if (frame_tally != 32'hFFFF_FFFF) begin
               frame_tally = frame_tally + 32'd1;
               total = 64'(load_total) + load;
               load_total = (total > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF
                                                          : total[47:0];
            end
         end
         ACT_OVERRUN: begin
            if (overrun_tally != 32'hFFFF_FFFF) overrun_tally = overrun_tally + 32'd1;
         end
         ACT_CLEAR: begin
            last_load     = '0;
            ema_q16       = '0;
            peak_q16      = '0;
            load_total    = '0;
            frame_tally   = '0;
            overrun_tally = '0;
         end
         default: begin
         end
      endcase

      mean = (frame_tally == 0) ? 64'd0 : 64'(load_total) / 64'(frame_tally);
      if (mean > 64'hFFFF) mean = 64'hFFFF;

      rpt.spare    = 1'b0;
      rpt.current  = last_load;
      rpt.smoothed = ema_q16[31:16];
      rpt.peak     = peak_q16[31:16];
      rpt.average  = mean[15:0];
      rpt.headroom = (ema_q16[31:16] >= 16'(FULL_LOAD)) ? 15'd0
                                                         : FULL_LOAD - ema_q16[30:16];
      rpt.overruns = overrun_tally;
      rpt.frames   = frame_tally;
      return rpt;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Request side. The valid is lowered only when a gap follows, so a request
   // that is followed straight away by another keeps tvalid high throughout.
   // ---------------------------------------------------------------------------
   task automatic send_request(input logic [1:0] action, input logic [31:0] elapsed,
                               input logic [31:0] now, input logic typed,
                               input load_report_type want);
      int unsigned     gap;
      load_report_type predicted;

      gap = 0;
      while ($urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {now, elapsed};
      req_tuser  <= action;
      do @(posedge clock); while (!req_tready);

      // The shadow state must advance even when the result is typed in.
      predicted = advance_monitor(action, elapsed, now);
      reports_due.push_back(typed ? want : predicted);
   endtask

   // Register writes happen only with no request in flight. Every request gives
   // exactly one result, so an empty queue means the block has gone idle.
   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      req_tvalid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);

      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;

      case (index)
         REG_BUDGET:    budget_cfg    = value;
         REG_SMOOTHING: smoothing_cfg = value[16:0];
         REG_PEAK_HOLD: hold_cfg      = value;
         default: begin
         end
      endcase
   endtask

   // One idling pattern over three register settings. Loads mostly land near
   // the budget so that the average and the peak hold see real movement.
   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
      logic [31:0] budget;
      logic [31:0] value;
      logic [31:0] elapsed;
      logic [63:0] stretched;
      logic [1:0]  action;
      int unsigned pick;

      for (int setting = 0; setting < 3; setting++) begin
         case ($urandom_range(0, 9))
            0:       budget = '0;
            1:       budget = 32'd1;
            2:       budget = 32'hFFFF_FFFF;
            3:       budget = $urandom;
            default: budget = $urandom_range(1000, 2000000);
         endcase
         write_register(REG_BUDGET, budget);

         case ($urandom_range(0, 4))
            0:       value = $urandom_range(0, 66);
            1:       value = 32'd65536;
            2:       value = $urandom_range(65536, 131071);
            3:       value = $urandom & 32'h0001_FFFF;
            default: value = $urandom_range(66, 65535);
         endcase
         write_register(REG_SMOOTHING, value);

         case ($urandom_range(0, 5))
            0:       value = '0;
            1:       value = 32'hFFFF_FFFF;
            2:       value = $urandom;
            default: value = $urandom_range(0, 5000);
         endcase
         write_register(REG_PEAK_HOLD, value);

         sender_idle_pct    = idle_pct;
         receiver_stall_pct = stall_pct;

         for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 82)      action = ACT_FRAME;
            else if (pick < 93) action = ACT_OVERRUN;
            else if (pick < 97) action = ACT_CLEAR;
            else                action = ACT_UNUSED;

            case ($urandom_range(0, 9))
               0: elapsed = '0;
               1: elapsed = $urandom;
               2: elapsed = 32'hFFFF_FFFF - $urandom_range(0, 3);
               default: begin
                  stretched = (64'(budget) * $urandom_range(0, 160)) / 100
                              + $urandom_range(0, 15);
                  elapsed = (stretched > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : stretched[31:0];
               end
            endcase

            // The timestamp mostly moves forward by about a hold time, now and
            // then it jumps, and it wraps freely.
            if ($urandom_range(0, 19) == 0) now_cursor = $urandom;
            else now_cursor = now_cursor + $urandom_range(0, 3000);

            send_request(action, elapsed, now_cursor, 1'b0, NO_REPORT);
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Clock and main sequence.
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : main_sequence
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed steps, straight after reset, with no idling on either side.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (DIRECTED_PLAN[i].kind == ROW_REGISTER) begin
            write_register(DIRECTED_PLAN[i].code, DIRECTED_PLAN[i].arg_a);
         end else begin
            send_request(DIRECTED_PLAN[i].code, DIRECTED_PLAN[i].arg_a,
                         DIRECTED_PLAN[i].arg_b, DIRECTED_PLAN[i].typed,
                         DIRECTED_PLAN[i].want);
         end
      end

      // Random phases: smooth flow, a mostly idle sender, a mostly stalling
      // receiver, then both sides idling a third of the time.
      now_cursor = $urandom;
      run_phase(0, 0);
      run_phase(88, 0);
      run_phase(0, 88);
      run_phase(36, 36);

      req_tvalid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0 && reports_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Result side. Every few hundred results the receiver holds off for a long
   // spell while requests keep coming, so the block fills and stops taking
   // requests. Handshakes are counted here, at the edges this process sees.
   // ---------------------------------------------------------------------------
   initial begin : result_sink
      int unsigned handshakes;
      int unsigned hold_left;

      handshakes = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            handshakes++;
            if (handshakes % 300 == 100) hold_left = 400;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   // Each accepted result is matched against the oldest expected one.
   initial begin : result_check
      load_report_type got;
      load_report_type want;

      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = load_report_type'(rsp_tdata);
            if (reports_due.size() == 0) begin
               $display("%0t: result with no request outstanding, expected none, actual %h",
                        $time, rsp_tdata);
               error_count++;
            end else begin
               want = reports_due.pop_front();
               compare_field("current_load",  32'(want.current),  32'(got.current));
               compare_field("smoothed_load", 32'(want.smoothed), 32'(got.smoothed));
               compare_field("peak_load",     32'(want.peak),     32'(got.peak));
               compare_field("average_load",  32'(want.average),  32'(got.average));
               compare_field("headroom",      32'(want.headroom), 32'(got.headroom));
               compare_field("overrun_count", want.overruns,      got.overruns);
               compare_field("frame_count",   want.frames,        got.frames);
            end
         end
      end
   end

   // A run that stops moving counts as a failure.
   initial begin : watchdog
      int unsigned quiet_cycles;

      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("Verification failed");
      $finish;
   end

endmodule
